// ===== rtl/curvilinear_grid_gradient_unit_assert.svh =====
// assertion macros for the grid gradient unit
`ifndef CURVILINEAR_GRID_GRADIENT_UNIT_ASSERT_SVH
`define CURVILINEAR_GRID_GRADIENT_UNIT_ASSERT_SVH
// a implies b in the same cycle
`define CGG_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// a implies b in the next cycle
`define CGG_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== rtl/cgg_pkg.sv =====
// shared constants and types of the grid gradient unit
package cgg_pkg;
	localparam int SIDE_POINTS_DEF = 64;
	localparam int DATA_BITS_DEF   = 32;
	localparam int FRAC_BITS       = 16;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_COMPUTE = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic [1:0] REQ_NONE    = 2'd3;

	localparam logic [1:0] REG_NX   = 2'd0;
	localparam logic [1:0] REG_NY   = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	// sequencer states
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_FETCH = 9'b000000010,
		ST_WAIT  = 9'b000000100,
		ST_MUL   = 9'b000001000,
		ST_DIV   = 9'b000010000,
		ST_STORE = 9'b000100000,
		ST_NEXT  = 9'b001000000,
		ST_READ  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/curvilinear_grid_gradient_unit.sv =====
// grid gradient and laplacian unit: top level with sequencer and point stores
// a write beat is taken every cycle while idle; a read beat holds busy in ST_READ and ST_DONE
// a compute beat sweeps (nx+1)*(ny+1) points, nx, ny clamped to 2..min(SIDE_POINTS-1,63),
// twice in laplacian mode; each point: six taps, six products, two divisions if jacobian != 0
// results show for one cycle under result_valid; the receiver cannot stall
// arst_n clears the sequencer and config registers; stores are undefined until written
module curvilinear_grid_gradient_unit #(
	parameter int SIDE_POINTS = cgg_pkg::SIDE_POINTS_DEF,
	parameter int DATA_BITS   = cgg_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [5:0]                  xi_index,
	input  logic [5:0]                  eta_index,
	input  logic signed [DATA_BITS-1:0] coord_x,
	input  logic signed [DATA_BITS-1:0] coord_y,
	input  logic signed [DATA_BITS-1:0] func_value,
	output logic                        result_valid,
	output logic                        result_kind,
	output logic signed [DATA_BITS-1:0] deriv_x,
	output logic signed [DATA_BITS-1:0] deriv_y,
	output logic signed [DATA_BITS-1:0] laplacian_out,
	output logic                        degenerate
);
	`include "curvilinear_grid_gradient_unit_assert.svh"

	localparam int IW    = $clog2(SIDE_POINTS);
	localparam int AW    = 2 * IW;
	localparam int DEPTH = 1 << AW;
	localparam int DW    = DATA_BITS + 3;
	localparam int PW    = 2 * DW + 2;
	localparam int NW    = 2 * DATA_BITS + 8;
	localparam int CNT_HI = (SIDE_POINTS - 1 < 63) ? SIDE_POINTS - 1 : 63;

	// point stores and result stores, addressed {eta, xi}
	logic [DATA_BITS-1:0] x_mem [DEPTH];
	logic [DATA_BITS-1:0] y_mem [DEPTH];
	logic [DATA_BITS-1:0] u_mem [DEPTH];
	logic [DATA_BITS-1:0] gx_mem [DEPTH];
	logic [DATA_BITS-1:0] gy_mem [DEPTH];
	logic [DATA_BITS-1:0] lp_mem [DEPTH];
	logic                 dg_mem [DEPTH];

	logic [5:0] nx_q, ny_q;
	logic       mode_q;
	cgg_pkg::state_t st_q;

	logic [IW-1:0] i_q, j_q;
	logic          pass2_q;
	logic          passdeg_q;
	logic [2:0]    tap_q;   // stencil fetch index, 0..5
	logic          rdin_q;
	logic [AW-1:0] raddr_q;

	logic signed [DATA_BITS-1:0] ra_x, ra_y, ra_u, ra_gx, ra_gy, ra_lp;
	logic                        ra_dg;
	logic signed [DATA_BITS-1:0] sx_q [6];
	logic signed [DATA_BITS-1:0] sy_q [6];
	logic signed [DATA_BITS-1:0] su_q [6];
	logic signed [DATA_BITS-1:0] sv_q [6];

	logic signed [DW-1:0] xa, xb, ya, yb, ua, ub, va, vb;
	logic [2:0]           mstep_q;
	logic signed [PW-1:0] p1_q, jac_q, n1_q, n2_q;
	logic signed [DATA_BITS-1:0] q1_q;
	logic                 dsel_q;
	logic                 dstart;
	logic signed [NW-1:0] dnum;
	cgg_pkg::div_ctl_t    dctl;
	logic signed [DATA_BITS-1:0] dquo;

	logic [5:0] nx_c, ny_c;
	logic       wr_cfg;
	logic       accept;

	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	assign accept = start && !busy;
	assign busy   = (st_q != cgg_pkg::ST_IDLE);

	always_comb begin
		nx_c = (nx_q < 6'd2) ? 6'd2 : ((nx_q > 6'(CNT_HI)) ? 6'(CNT_HI) : nx_q);
		ny_c = (ny_q < 6'd2) ? 6'd2 : ((ny_q > 6'(CNT_HI)) ? 6'(CNT_HI) : ny_q);
	end

	always_comb begin
		unique case (paddr[3:2])
			cgg_pkg::REG_NX:   prdata = {26'd0, nx_q};
			cgg_pkg::REG_NY:   prdata = {26'd0, ny_q};
			cgg_pkg::REG_MODE: prdata = {31'd0, mode_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q   <= 6'd2;
			ny_q   <= 6'd2;
			mode_q <= 1'b0;
		end else if (wr_cfg) begin
			unique case (paddr[3:2])
				cgg_pkg::REG_NX:   nx_q   <= pwdata[5:0];
				cgg_pkg::REG_NY:   ny_q   <= pwdata[5:0];
				cgg_pkg::REG_MODE: mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// stencil address for fetch tap: 0,1,2 along xi; 3,4,5 along eta
	logic [IW:0] ti, tj;
	logic [IW:0] ii, jj;
	logic [AW-1:0] taddr;
	assign ii = {1'b0, i_q};
	assign jj = {1'b0, j_q};
	always_comb begin
		ti = ii;
		tj = jj;
		case (tap_q)
			3'd0: ti = (i_q == '0) ? (IW+1)'(0) :
				((ii == (IW+1)'(nx_c)) ? ii : ii - 1'b1);
			3'd1: ti = (i_q == '0) ? (IW+1)'(1) :
				((ii == (IW+1)'(nx_c)) ? ii - 1'b1 : ii + 1'b1);
			3'd2: ti = (i_q == '0) ? (IW+1)'(2) : ii - 2'd2;
			3'd3: tj = (j_q == '0) ? (IW+1)'(0) :
				((jj == (IW+1)'(ny_c)) ? jj : jj - 1'b1);
			3'd4: tj = (j_q == '0) ? (IW+1)'(1) :
				((jj == (IW+1)'(ny_c)) ? jj - 1'b1 : jj + 1'b1);
			default: tj = (j_q == '0) ? (IW+1)'(2) : jj - 2'd2;
		endcase
		taddr = {tj[IW-1:0], ti[IW-1:0]};
	end

	logic in_rng;
	assign in_rng = ({3'b0, xi_index} < 9'(SIDE_POINTS)) && ({3'b0, eta_index} < 9'(SIDE_POINTS));

	logic [AW-1:0] waddr;
	assign waddr = {IW'(eta_index), IW'(xi_index)};

	logic [AW-1:0] rd_addr;
	assign rd_addr = (st_q == cgg_pkg::ST_FETCH) ? taddr : raddr_q;

	logic          wr_res;
	logic [AW-1:0] paddr_pt;
	logic signed [DATA_BITS-1:0] gx_w, gy_w, lp_w;
	logic          dg_w;
	assign paddr_pt = {j_q, i_q};

	always_ff @(posedge clk) begin
		if (accept && req_type == cgg_pkg::REQ_WRITE && in_rng) begin
			x_mem[waddr] <= coord_x;
			y_mem[waddr] <= coord_y;
			u_mem[waddr] <= func_value;
		end
		ra_x  <= x_mem[rd_addr];
		ra_y  <= y_mem[rd_addr];
		ra_u  <= u_mem[rd_addr];
		ra_gx <= gx_mem[rd_addr];
		ra_gy <= gy_mem[rd_addr];
		ra_lp <= lp_mem[rd_addr];
		ra_dg <= dg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_res) begin
			if (!pass2_q) begin
				gx_mem[paddr_pt] <= gx_w;
				gy_mem[paddr_pt] <= gy_w;
				dg_mem[paddr_pt] <= dg_w;
			end
			lp_mem[paddr_pt] <= lp_w;
		end
	end

	// differences: centred, or one-sided three point
	function automatic logic signed [DW-1:0] diff3(
		input logic signed [DATA_BITS-1:0] a,
		input logic signed [DATA_BITS-1:0] b,
		input logic signed [DATA_BITS-1:0] c,
		input logic                        lo,
		input logic                        hi
	);
		logic signed [DW-1:0] e;
		begin
			e = (DW'(b) <<< 2) - DW'(c) - DW'(a) - (DW'(a) <<< 1);
			if (lo)
				diff3 = e;
			else if (hi)
				diff3 = -e;
			else
				diff3 = DW'(b) - DW'(a);
		end
	endfunction

	logic xlo, xhi, ylo, yhi;
	assign xlo = (i_q == '0);
	assign xhi = ({1'b0, i_q} == (IW+1)'(nx_c));
	assign ylo = (j_q == '0);
	assign yhi = ({1'b0, j_q} == (IW+1)'(ny_c));

	always_comb begin
		xa = diff3(sx_q[0], sx_q[1], sx_q[2], xlo, xhi);
		xb = diff3(sx_q[3], sx_q[4], sx_q[5], ylo, yhi);
		ya = diff3(sy_q[0], sy_q[1], sy_q[2], xlo, xhi);
		yb = diff3(sy_q[3], sy_q[4], sy_q[5], ylo, yhi);
		ua = diff3(su_q[0], su_q[1], su_q[2], xlo, xhi);
		ub = diff3(su_q[3], su_q[4], su_q[5], ylo, yhi);
		va = diff3(sv_q[0], sv_q[1], sv_q[2], xlo, xhi);
		vb = diff3(sv_q[3], sv_q[4], sv_q[5], ylo, yhi);
	end

	// shared multiplier: one product per step
	logic signed [DW-1:0] ma, mb;
	logic signed [PW-1:0] prod;
	always_comb begin
		ma = xa; mb = yb;
		case (mstep_q)
			3'd0: begin ma = xa; mb = yb; end
			3'd1: begin ma = xb; mb = ya; end
			3'd2: begin ma = pass2_q ? ua : ua; mb = yb; end
			3'd3: begin ma = ub; mb = ya; end
			3'd4: begin ma = pass2_q ? vb : ub; mb = xa; end
			default: begin ma = pass2_q ? va : ua; mb = xb; end
		endcase
		prod = PW'(ma) * PW'(mb);
	end

	assign dstart = (st_q == cgg_pkg::ST_DIV) && !dctl.busy && !dctl.done && !dsel_q
		|| (st_q == cgg_pkg::ST_DIV) && !dctl.busy && dsel_q && !dctl.done;
	assign dnum = dsel_q ? NW'(n2_q) : NW'(n1_q);

	cgg_divider #(
		.DATA_BITS(DATA_BITS),
		.NUM_BITS (NW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (dstart),
		.num   (dnum),
		.den   (NW'(jac_q)),
		.ctl   (dctl),
		.quo   (dquo)
	);

	logic signed [DATA_BITS:0] lsum;
	logic jzero;
	assign lsum  = (DATA_BITS+1)'(q1_q) + (DATA_BITS+1)'(dquo);
	assign jzero = (jac_q == '0);

	always_comb begin
		gx_w = q1_q;
		gy_w = dquo;
		dg_w = 1'b0;
		lp_w = '0;
		if (pass2_q) begin
			if (lsum[DATA_BITS] != lsum[DATA_BITS-1])
				lp_w = lsum[DATA_BITS] ? {1'b1, {(DATA_BITS-1){1'b0}}}
					: {1'b0, {(DATA_BITS-1){1'b1}}};
			else
				lp_w = lsum[DATA_BITS-1:0];
		end else if (jzero) begin
			gx_w = '0;
			gy_w = '0;
			dg_w = 1'b1;
		end
	end
	assign wr_res = (st_q == cgg_pkg::ST_STORE) && !(pass2_q && jzero);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= cgg_pkg::ST_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			pass2_q      <= 1'b0;
			passdeg_q    <= 1'b0;
			tap_q        <= '0;
			mstep_q      <= '0;
			dsel_q       <= 1'b0;
			result_valid <= 1'b0;
			rdin_q       <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (st_q)
				cgg_pkg::ST_IDLE: begin
					if (accept) begin
						if (req_type == cgg_pkg::REQ_COMPUTE) begin
							st_q      <= cgg_pkg::ST_FETCH;
							i_q       <= '0;
							j_q       <= '0;
							tap_q     <= '0;
							pass2_q   <= 1'b0;
							passdeg_q <= 1'b0;
						end else if (req_type == cgg_pkg::REQ_READ) begin
							st_q   <= cgg_pkg::ST_READ;
							rdin_q <= in_rng;
						end
					end
				end
				cgg_pkg::ST_FETCH: begin
					st_q <= cgg_pkg::ST_WAIT;
				end
				cgg_pkg::ST_WAIT: begin
					if (tap_q == 3'd5) begin
						tap_q   <= '0;
						mstep_q <= '0;
						st_q    <= cgg_pkg::ST_MUL;
					end else begin
						tap_q <= tap_q + 1'b1;
						st_q  <= cgg_pkg::ST_FETCH;
					end
				end
				cgg_pkg::ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == 3'd5) begin
						dsel_q <= 1'b0;
						st_q   <= jzero ? cgg_pkg::ST_STORE : cgg_pkg::ST_DIV;
					end
				end
				cgg_pkg::ST_DIV: begin
					if (dctl.done) begin
						if (!dsel_q)
							dsel_q <= 1'b1;
						else
							st_q <= cgg_pkg::ST_STORE;
					end
				end
				cgg_pkg::ST_STORE: begin
					if (!pass2_q && jzero)
						passdeg_q <= 1'b1;
					st_q <= cgg_pkg::ST_NEXT;
				end
				cgg_pkg::ST_NEXT: begin
					st_q <= cgg_pkg::ST_FETCH;
					if ({1'b0, j_q} == (IW+1)'(ny_c)) begin
						j_q <= '0;
						if ({1'b0, i_q} == (IW+1)'(nx_c)) begin
							i_q <= '0;
							if (!pass2_q && mode_q)
								pass2_q <= 1'b1;
							else
								st_q <= cgg_pkg::ST_DONE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				cgg_pkg::ST_READ: begin
					st_q <= cgg_pkg::ST_DONE;
				end
				cgg_pkg::ST_DONE: begin
					result_valid <= 1'b1;
					st_q         <= cgg_pkg::ST_IDLE;
				end
				default: st_q <= cgg_pkg::ST_IDLE;
			endcase
		end
	end

	// read kind tracked separately
	logic read_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			read_q <= 1'b0;
		else if (accept)
			read_q <= (req_type == cgg_pkg::REQ_READ);
	end

	always_ff @(posedge clk) begin
		if (st_q == cgg_pkg::ST_READ) begin
			raddr_q <= raddr_q;
		end else if (accept) begin
			raddr_q <= waddr;
		end
		if (st_q == cgg_pkg::ST_WAIT) begin
			sx_q[tap_q] <= ra_x;
			sy_q[tap_q] <= ra_y;
			su_q[tap_q] <= pass2_q ? ra_gx : ra_u;
			sv_q[tap_q] <= ra_gy;
		end
		if (st_q == cgg_pkg::ST_MUL) begin
			case (mstep_q)
				3'd0: p1_q  <= prod;
				3'd1: jac_q <= p1_q - prod;
				3'd2: p1_q  <= prod;
				3'd3: n1_q  <= p1_q - prod;
				3'd4: p1_q  <= prod;
				default: n2_q <= p1_q - prod;
			endcase
		end
		if (st_q == cgg_pkg::ST_DIV && dctl.done && !dsel_q)
			q1_q <= dquo;
		if (st_q == cgg_pkg::ST_DONE) begin
			result_kind   <= read_q;
			deriv_x       <= (read_q && rdin_q) ? ra_gx : '0;
			deriv_y       <= (read_q && rdin_q) ? ra_gy : '0;
			laplacian_out <= (read_q && rdin_q) ? ra_lp : '0;
			degenerate    <= read_q ? (rdin_q && ra_dg) : passdeg_q;
		end
	end

	`CGG_ASSERT_IMP(a_busy_no_idle, clk, arst_n, result_valid, !busy)
	`CGG_ASSERT_NEXT(a_accept_busy, clk, arst_n,
		accept && (req_type == cgg_pkg::REQ_COMPUTE || req_type == cgg_pkg::REQ_READ), busy)
	`CGG_ASSERT_IMP(a_div_in_div, clk, arst_n, dctl.busy, st_q == cgg_pkg::ST_DIV)
endmodule

// ===== rtl/cgg_divider.sv =====
// restoring divider for num * 2^frac / den, truncated, saturated
module cgg_divider #(
	parameter int DATA_BITS = cgg_pkg::DATA_BITS_DEF,
	parameter int NUM_BITS  = 2 * DATA_BITS + 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [NUM_BITS-1:0]  num,
	input  logic signed [NUM_BITS-1:0]  den,
	output cgg_pkg::div_ctl_t           ctl,
	output logic signed [DATA_BITS-1:0] quo
);
	localparam int NB = NUM_BITS + cgg_pkg::FRAC_BITS;
	localparam int CW = $clog2(NB + 1);
	localparam logic [NB:0] QMAX = {{(NB - DATA_BITS + 2){1'b0}}, {(DATA_BITS - 1){1'b1}}};

	logic [NB-1:0] n_q;
	logic [NB-1:0] q_q;
	logic [NB:0]   r_q;
	logic [NB:0]   d_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NB:0]   r_sh;
	logic [NB:0]   qmag;

	assign r_sh = {r_q[NB-1:0], n_q[NB-1]};
	assign qmag = {1'b0, q_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			n_q   <= {(num[NUM_BITS-1] ? NUM_BITS'(-num) : num), {cgg_pkg::FRAC_BITS{1'b0}}};
			d_q   <= (NB+1)'(den[NUM_BITS-1] ? NUM_BITS'(-den) : den);
			neg_q <= num[NUM_BITS-1] ^ den[NUM_BITS-1];
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NB-2:0], 1'b0};
			if (r_sh >= d_q) begin
				r_q <= r_sh - d_q;
				q_q <= {q_q[NB-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (neg_q) begin
			if (qmag > QMAX)
				quo = {1'b1, {(DATA_BITS - 1){1'b0}}};
			else
				quo = DATA_BITS'(-qmag);
		end else if (qmag > QMAX) begin
			quo = {1'b0, {(DATA_BITS - 1){1'b1}}};
		end else begin
			quo = qmag[DATA_BITS-1:0];
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign ctl.done  = done_q;
endmodule

// ===== sim/curvilinear_grid_gradient_unit_tb.sv =====
// testbench for the grid gradient unit: directed and random beats checked against an inline predictor
module curvilinear_grid_gradient_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIDE = 64;
	localparam int DEPTH = SIDE * SIDE;
	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam int RANDOM_BEATS = 1750;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [31:0] q16_t;
	typedef enum int {F_X, F_Y, F_U, F_GX, F_GY} grid_field_t;
	typedef enum int {FILL_SMOOTH, FILL_RANDOM, FILL_FLAT, FILL_EXTREME} fill_style_t;
	typedef struct {
		logic kind;
		q16_t dx;
		q16_t dy;
		q16_t lap;
		logic deg;
	} grid_result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic [1:0] req_type = 0;
	logic [5:0] xi_index = 0;
	logic [5:0] eta_index = 0;
	q16_t coord_x = 0;
	q16_t coord_y = 0;
	q16_t func_value = 0;
	logic result_valid;
	logic result_kind;
	q16_t deriv_x;
	q16_t deriv_y;
	q16_t laplacian_out;
	logic degenerate;

	curvilinear_grid_gradient_unit dut (.*);

	q16_t x_mem [DEPTH];
	q16_t y_mem [DEPTH];
	q16_t u_mem [DEPTH];
	q16_t gx_mem [DEPTH];
	q16_t gy_mem [DEPTH];
	q16_t lap_mem [DEPTH];
	bit pt_deg [DEPTH];
	bit swept [DEPTH];
	bit pass_deg;
	logic [5:0] cfg_nx = 2;
	logic [5:0] cfg_ny = 2;
	logic cfg_lap = 0;

	grid_result_t pending_results[$];
	grid_result_t head;
	int errors = 0;
	longint cycles = 0;
	int beats_sent = 0;
	bit idle_on = 1;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	function automatic int span(logic [5:0] n);
		if (n < 2) return 2;
		if (n > SIDE - 1) return SIDE - 1;
		return n;
	endfunction

	function automatic q16_t field_at(grid_field_t f, int p);
		case (f)
			F_X: return x_mem[p];
			F_Y: return y_mem[p];
			F_U: return u_mem[p];
			F_GX: return gx_mem[p];
			default: return gy_mem[p];
		endcase
	endfunction

	function automatic wide_t ext(q16_t v);
		return wide_t'(v);
	endfunction

	function automatic wide_t edge_diff(q16_t a, q16_t b, q16_t c, bit up);
		wide_t w;
		w = 4 * ext(b) - ext(c) - 3 * ext(a);
		return up ? -w : w;
	endfunction

	function automatic void grid_diffs(grid_field_t f, int i, int j, int nx, int ny,
			output wide_t dxi, output wide_t deta);
		int r;
		r = j * SIDE;
		if (i > 0 && i < nx)
			dxi = ext(field_at(f, r + i + 1)) - ext(field_at(f, r + i - 1));
		else if (i == 0)
			dxi = edge_diff(field_at(f, r), field_at(f, r + 1), field_at(f, r + 2), 0);
		else
			dxi = edge_diff(field_at(f, r + i), field_at(f, r + i - 1), field_at(f, r + i - 2), 1);
		if (j > 0 && j < ny)
			deta = ext(field_at(f, r + SIDE + i)) - ext(field_at(f, r - SIDE + i));
		else if (j == 0)
			deta = edge_diff(field_at(f, i), field_at(f, SIDE + i), field_at(f, 2 * SIDE + i), 0);
		else
			deta = edge_diff(field_at(f, r + i), field_at(f, r - SIDE + i),
				field_at(f, r - 2 * SIDE + i), 1);
	endfunction

	function automatic q16_t sat32(wide_t v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic q16_t scaled_quotient(wide_t num, wide_t den);
		wide_t n;
		n = num <<< 16;
		return sat32(n / den);
	endfunction

	function automatic void sweep_grid();
		int nx, ny, p;
		wide_t xa, xb, ya, yb, ua, ub, ga, gb, ha, hb, jac;
		q16_t lx, ly;
		nx = span(cfg_nx);
		ny = span(cfg_ny);
		pass_deg = 0;
		for (int i = 0; i <= nx; i++)
			for (int j = 0; j <= ny; j++) begin
				p = j * SIDE + i;
				grid_diffs(F_X, i, j, nx, ny, xa, xb);
				grid_diffs(F_Y, i, j, nx, ny, ya, yb);
				grid_diffs(F_U, i, j, nx, ny, ua, ub);
				jac = xa * yb - xb * ya;
				lap_mem[p] = 0;
				swept[p] = 1;
				if (jac == 0) begin
					gx_mem[p] = 0;
					gy_mem[p] = 0;
					pt_deg[p] = 1;
					pass_deg = 1;
				end else begin
					gx_mem[p] = scaled_quotient(ua * yb - ub * ya, jac);
					gy_mem[p] = scaled_quotient(ub * xa - ua * xb, jac);
					pt_deg[p] = 0;
				end
			end
		if (!cfg_lap) return;
		for (int i = 0; i <= nx; i++)
			for (int j = 0; j <= ny; j++) begin
				p = j * SIDE + i;
				grid_diffs(F_X, i, j, nx, ny, xa, xb);
				grid_diffs(F_Y, i, j, nx, ny, ya, yb);
				jac = xa * yb - xb * ya;
				if (jac != 0) begin
					grid_diffs(F_GX, i, j, nx, ny, ga, gb);
					grid_diffs(F_GY, i, j, nx, ny, ha, hb);
					lx = scaled_quotient(ga * yb - gb * ya, jac);
					ly = scaled_quotient(hb * xa - ha * xb, jac);
					lap_mem[p] = sat32(ext(lx) + ext(ly));
				end
			end
	endfunction

	function automatic void predict_beat(logic [1:0] rt, logic [5:0] xi, logic [5:0] eta,
			q16_t cx, q16_t cy, q16_t fv);
		int p;
		grid_result_t r;
		p = eta * SIDE + xi;
		if (rt == cgg_pkg::REQ_WRITE) begin
			x_mem[p] = cx;
			y_mem[p] = cy;
			u_mem[p] = fv;
		end else if (rt == cgg_pkg::REQ_COMPUTE) begin
			sweep_grid();
			r = '{kind: 1'b0, dx: 0, dy: 0, lap: 0, deg: pass_deg};
			pending_results.push_back(r);
		end else if (rt == cgg_pkg::REQ_READ) begin
			r = '{kind: 1'b1, dx: gx_mem[p], dy: gy_mem[p], lap: lap_mem[p], deg: pt_deg[p]};
			pending_results.push_back(r);
		end
	endfunction

	task automatic check_field(string what, q16_t want, q16_t got);
		if (want !== got) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t result beat expected none actual kind %0d", $time, result_kind);
			end else begin
				head = pending_results.pop_front();
				check_field("result_kind", head.kind, result_kind);
				check_field("deriv_x", head.dx, deriv_x);
				check_field("deriv_y", head.dy, deriv_y);
				check_field("laplacian_out", head.lap, laplacian_out);
				check_field("degenerate", head.deg, degenerate);
			end
		end
	end

	task automatic send_req(logic [1:0] rt, logic [5:0] xi, logic [5:0] eta,
			q16_t cx, q16_t cy, q16_t fv);
		int gap;
		start <= 1;
		req_type <= rt;
		xi_index <= xi;
		eta_index <= eta;
		coord_x <= cx;
		coord_y <= cy;
		func_value <= fv;
		do @(posedge clk); while (busy);
		predict_beat(rt, xi, eta, cx, cy, fv);
		beats_sent++;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_compute();
		send_req(cgg_pkg::REQ_COMPUTE, $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom());
	endtask

	task automatic send_read(int i, int j);
		send_req(cgg_pkg::REQ_READ, i, j, $urandom(), $urandom(), $urandom());
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
		start <= 0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			cgg_pkg::REG_NX: cfg_nx = data[5:0];
			cgg_pkg::REG_NY: cfg_ny = data[5:0];
			cgg_pkg::REG_MODE: cfg_lap = data[0];
			default: ;
		endcase
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic set_grid(logic [5:0] nx, logic [5:0] ny, logic lap);
		cfg_write(cgg_pkg::REG_NX, {$urandom() & 32'hffffffc0} | nx);
		cfg_write(cgg_pkg::REG_NY, {$urandom() & 32'hffffffc0} | ny);
		cfg_write(cgg_pkg::REG_MODE, {$urandom() & 32'hfffffffe} | lap);
	endtask

	task automatic fill_grid(fill_style_t style);
		int nx, ny, sx, sy, kx, ky, ua, ub;
		q16_t cx, cy, fv;
		q16_t lim [3];
		lim = '{32'sh80000000, 0, 32'sh7fffffff};
		nx = span(cfg_nx);
		ny = span(cfg_ny);
		sx = $urandom_range(1, 256) << 10;
		sy = $urandom_range(1, 256) << 10;
		kx = $urandom_range(0, 4095) - 2048;
		ky = $urandom_range(0, 4095) - 2048;
		ua = $urandom_range(0, 1 << 20) - (1 << 19);
		ub = $urandom_range(0, 1 << 20) - (1 << 19);
		for (int i = 0; i <= nx; i++)
			for (int j = 0; j <= ny; j++) begin
				case (style)
					FILL_SMOOTH: begin
						cx = i * sx + j * kx + $urandom_range(0, 255) - 128;
						cy = j * sy + i * ky + $urandom_range(0, 255) - 128;
						fv = i * ua + j * ub + (q16_t'($urandom()) >>> $urandom_range(8, 31));
					end
					FILL_RANDOM: begin
						cx = $urandom();
						cy = $urandom();
						fv = $urandom();
					end
					FILL_FLAT: begin
						cx = i * sx;
						cy = $urandom_range(0, 1) ? 0 : j * sy;
						fv = $urandom();
					end
					default: begin
						cx = lim[i % 3];
						cy = lim[(j + i / 3) % 3];
						fv = lim[(i + j) % 3];
					end
				endcase
				send_req(cgg_pkg::REQ_WRITE, i, j, cx, cy, fv);
			end
	endtask

	task automatic read_some(int n);
		int p;
		for (int k = 0; k < n; k++)
			if ($urandom_range(0, 4) != 0) begin
				send_read($urandom_range(0, span(cfg_nx)), $urandom_range(0, span(cfg_ny)));
			end else begin
				do p = $urandom_range(0, DEPTH - 1); while (!swept[p]);
				send_read(p % SIDE, p / SIDE);
			end
	endtask

	task automatic test_extremes();
		fill_grid(FILL_EXTREME);
		send_compute();
		send_read(0, 0);
		send_read(1, 1);
		send_read(2, 2);
		send_read(2, 0);
	endtask

	task automatic test_degenerate();
		fill_grid(FILL_FLAT);
		send_compute();
		read_some(3);
	endtask

	task automatic test_unused_req();
		send_req(cgg_pkg::REQ_NONE, 6'd63, 6'd63, $urandom(), $urandom(), $urandom());
		send_req(cgg_pkg::REQ_NONE, 6'd0, 6'd0, $urandom(), $urandom(), $urandom());
	endtask

	task automatic test_interval_clamp();
		set_grid(6'd0, 6'd1, 1'b1);
		fill_grid(FILL_SMOOTH);
		send_compute();
		read_some(4);
	endtask

	task automatic test_wide_grid();
		set_grid(6'd63, 6'd2, 1'b1);
		fill_grid(FILL_SMOOTH);
		send_compute();
		send_read(63, 2);
		send_read(0, 0);
		read_some(4);
		set_grid(6'd2, 6'd63, 1'b0);
		fill_grid(FILL_SMOOTH);
		send_compute();
		send_read(2, 63);
		read_some(4);
	endtask

	task automatic test_random_rounds();
		int pick;
		while (beats_sent < RANDOM_BEATS) begin
			idle_on = $urandom_range(0, 3) != 0;
			set_grid($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 1));
			pick = $urandom_range(0, 9);
			fill_grid(pick < 6 ? FILL_SMOOTH : pick < 8 ? FILL_RANDOM :
				pick < 9 ? FILL_FLAT : FILL_EXTREME);
			repeat ($urandom_range(0, 4)) begin
				if ($urandom_range(0, 3) == 0)
					send_req(cgg_pkg::REQ_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
						$urandom());
				else
					send_req(cgg_pkg::REQ_WRITE, $urandom(), $urandom(), $urandom(), $urandom(),
						$urandom());
			end
			send_compute();
			read_some($urandom_range(5, 15));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_extremes();
		test_degenerate();
		test_unused_req();
		test_interval_clamp();
		test_wide_grid();
		test_random_rounds();
		start <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
